[hw/rtl/tdc_pkg.sv]
package tdc_pkg;

    localparam int NUM_STATES = 64;
    localparam int NUM_KINDS  = 16;
    localparam int SYMBOLS    = 256;

    localparam int OP_W    = 2;
    localparam int STATE_W = 6;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;

    localparam int TT_DEPTH = NUM_STATES * SYMBOLS;
    localparam int TT_AW    = $clog2(TT_DEPTH);

    localparam logic [STATE_W-1:0] START_STATE = STATE_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_WR_TRANS  = 2'd0,
        OP_WR_ACCEPT = 2'd1,
        OP_SCAN      = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_LOAD
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic step;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic scan_last;
        logic out_busy;
    } status_t;

    function automatic logic state_in_range(input logic [STATE_W-1:0] st);
        return ({1'b0, st} < (STATE_W + 1)'(NUM_STATES));
    endfunction

endpackage

[hw/rtl/table_dfa_token_classifier.sv]
// Table-driven DFA token classifier. Words with op 0 load one transition entry
// (row_state, byte_value -> next_state), op 1 sets or clears the accept entry of
// row_state, op 2 steps the current state with one byte; a scan word with last
// set returns matched and kind_out and puts the state back to 1. After reset the
// block clears its 16384-entry transition memory one entry per cycle and holds
// s_ready low during that sweep. A scan byte then passes a registered read of
// the transition memory, then the state update; a final byte also passes the
// accept table read and the result load. The state feedback through the single
// memory read port keeps new words out until a scan byte is through. One result
// word is buffered, so new words are taken while it waits on m_ready.
module table_dfa_token_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tdc_pkg::OP_W-1:0]      s_op,
    input  logic [tdc_pkg::STATE_W-1:0]   s_row_state,
    input  logic [tdc_pkg::BYTE_W-1:0]    s_byte_value,
    input  logic [tdc_pkg::STATE_W-1:0]   s_next_state,
    input  logic [tdc_pkg::KIND_W-1:0]    s_token_kind,
    input  logic                          s_accept_flag,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_matched,
    output logic [tdc_pkg::KIND_W-1:0]    m_kind_out
);
    import tdc_pkg::*;

    cmd_t    cmd;
    status_t status;
    op_t     op_in;

    assign op_in = op_t'(s_op);

    tdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op_in   (op_in),
        .status  (status),
        .cmd     (cmd)
    );

    tdc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .op_in       (op_in),
        .row_state   (s_row_state),
        .byte_value  (s_byte_value),
        .next_state  (s_next_state),
        .token_kind  (s_token_kind),
        .accept_flag (s_accept_flag),
        .last        (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_matched   (m_matched),
        .m_kind_out  (m_kind_out)
    );

endmodule

[hw/rtl/tdc_ctrl.sv]
module tdc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tdc_pkg::op_t      op_in,
    input  tdc_pkg::status_t  status,
    output tdc_pkg::cmd_t     cmd
);
    import tdc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && op_in == OP_SCAN) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                state_next = status.scan_last ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.clear_en = 1'b0;
        cmd.accept   = 1'b0;
        cmd.step     = 1'b0;
        cmd.load     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_STEP: begin
                cmd.step = 1'b1;
            end
            ST_LOAD: begin
                cmd.load = !status.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // result word never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !status.out_busy)
        else $error("output register overwritten");

    // one step per accepted scan word
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> $past(cmd.accept) && $past(op_in) == OP_SCAN)
        else $error("step without scan word");

    // no word taken while the transition memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_en |-> !cmd.accept && !cmd.step && !cmd.load)
        else $error("activity during clear sweep");

endmodule

[hw/rtl/tdc_datapath.sv]
module tdc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tdc_pkg::cmd_t                 cmd,
    output tdc_pkg::status_t              status,
    input  tdc_pkg::op_t                  op_in,
    input  logic [tdc_pkg::STATE_W-1:0]   row_state,
    input  logic [tdc_pkg::BYTE_W-1:0]    byte_value,
    input  logic [tdc_pkg::STATE_W-1:0]   next_state,
    input  logic [tdc_pkg::KIND_W-1:0]    token_kind,
    input  logic                          accept_flag,
    input  logic                          last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_matched,
    output logic [tdc_pkg::KIND_W-1:0]    m_kind_out
);
    import tdc_pkg::*;

    // transition memory, cleared by a sweep after reset
    logic [STATE_W-1:0] tt_mem [TT_DEPTH];
    logic [STATE_W-1:0] tt_rdata_reg;
    logic [TT_AW-1:0]   clr_cnt_reg;

    // accept table: kinds in memory, valid bits in flops
    logic [KIND_W-1:0]     kind_mem [NUM_STATES];
    logic [NUM_STATES-1:0] acc_valid_reg;
    logic [KIND_W-1:0]     kind_rd_reg;
    logic                  hit_reg;

    logic [STATE_W-1:0] cur_state_reg;
    logic               cur_oob_reg;
    logic               last_reg;

    logic               m_valid_reg;
    logic               m_matched_reg;
    logic [KIND_W-1:0]  m_kind_reg;

    logic               rd_en;
    logic               wr_trans;
    logic               wr_accept;
    logic [TT_AW-1:0]   rd_addr;
    logic [TT_AW-1:0]   wr_addr;
    logic [KIND_W-1:0]  kind_sat;
    logic [STATE_W-1:0] step_state;

    assign rd_en     = cmd.accept && op_in == OP_SCAN;
    assign wr_trans  = cmd.accept && op_in == OP_WR_TRANS && state_in_range(row_state);
    assign wr_accept = cmd.accept && op_in == OP_WR_ACCEPT && state_in_range(row_state);
    assign rd_addr   = TT_AW'({cur_state_reg, byte_value});
    assign wr_addr   = TT_AW'({row_state, byte_value});

    assign kind_sat = ({1'b0, token_kind} >= (KIND_W + 1)'(NUM_KINDS))
                    ? KIND_W'(NUM_KINDS - 1) : token_kind;

    // out-of-range source state leads to the dead state
    assign step_state = cur_oob_reg ? '0 : tt_rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            tt_mem[clr_cnt_reg] <= '0;
        end else if (wr_trans) begin
            tt_mem[wr_addr] <= next_state;
        end
        if (rd_en) begin
            tt_rdata_reg <= tt_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_accept) begin
            kind_mem[row_state] <= accept_flag ? kind_sat : '0;
        end
        if (cmd.step) begin
            kind_rd_reg <= kind_mem[step_state];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            acc_valid_reg <= '0;
            cur_state_reg <= START_STATE;
            cur_oob_reg   <= 1'b0;
            last_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.clear_en) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (wr_accept) begin
                acc_valid_reg[row_state] <= accept_flag;
            end
            if (rd_en) begin
                cur_oob_reg <= !state_in_range(cur_state_reg);
                last_reg    <= last;
            end
            if (cmd.step) begin
                cur_state_reg <= last_reg ? START_STATE : step_state;
                hit_reg       <= acc_valid_reg[step_state] && state_in_range(step_state);
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_matched_reg <= hit_reg;
            m_kind_reg    <= hit_reg ? kind_rd_reg : '0;
        end
    end

    assign status.clear_done = (clr_cnt_reg == TT_AW'(TT_DEPTH - 1));
    assign status.scan_last  = last_reg;
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign m_valid    = m_valid_reg;
    assign m_matched  = m_matched_reg;
    assign m_kind_out = m_kind_reg;

    // a string always restarts from the start state
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && last_reg |=> cur_state_reg == START_STATE)
        else $error("state not restored after last byte");

    // a result word appears only from a load
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.load))
        else $error("result word without load");

    // unmatched result carries no kind
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_matched_reg |-> m_kind_reg == '0)
        else $error("kind set on unmatched result");

endmodule
